>>> rtl/core/pwpd_pkg.sv
// ----------------------------------------------------------------------------
// pwpd_pkg
// Shared constants, types and helpers of the pulse-width packet decoder.
// ----------------------------------------------------------------------------
package pwpd_pkg;

    localparam int VALUES_PER_PACKAGE = 4;
    localparam int BITS_PER_VALUE     = 8;
    localparam int TOTAL_BITS         = VALUES_PER_PACKAGE * BITS_PER_VALUE;

    // The bit counter saturates at TOTAL_BITS + 1.
    localparam int CNT_W  = $clog2(TOTAL_BITS + 2);
    localparam int WORD_W = $clog2(VALUES_PER_PACKAGE + 1);
    localparam int ADDR_W = (VALUES_PER_PACKAGE > 1) ? $clog2(VALUES_PER_PACKAGE) : 1;
    localparam int BIT_W  = (BITS_PER_VALUE > 1) ? $clog2(BITS_PER_VALUE) : 1;

    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 3;
    localparam int VALUE_W   = 8;
    localparam int INDEX_W   = 6;

    localparam logic [TICK_W-1:0] ONE_PULSE_RESET   = 16'd800;
    localparam logic [TICK_W-1:0] ZERO_PULSE_RESET  = 16'd400;
    localparam logic [TICK_W-1:0] BIT_GAP_RESET     = 16'd400;
    localparam logic [TICK_W-1:0] FRAME_GAP_RESET   = 16'd4000;
    localparam logic [TICK_W-1:0] TOLERANCE_RESET   = 16'd100;

    typedef enum logic [STATUS_W-1:0] {
        ST_GAP_OK = 3'd0,
        ST_ONE    = 3'd1,
        ST_ZERO   = 3'd2,
        ST_ERROR  = 3'd3,
        ST_VALUE  = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_PULSE   = 3'd0,
        REG_ZERO_PULSE  = 3'd1,
        REG_BIT_GAP     = 3'd2,
        REG_FRAME_GAP   = 3'd3,
        REG_TOLERANCE   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] one_pulse;
        logic [TICK_W-1:0] zero_pulse;
        logic [TICK_W-1:0] bit_gap;
        logic [TICK_W-1:0] frame_gap;
        logic [TICK_W-1:0] tolerance;
    } cfg_t;

    // Outcome of the window checks on one interval.
    typedef struct packed {
        logic pkg_gap;
        logic gap_ok;
        logic one;
        logic zero;
    } class_t;

    // Fits one stored value into the output value field.
    function automatic logic [VALUE_W-1:0] to_value(input logic [BITS_PER_VALUE-1:0] x);
        logic [VALUE_W+BITS_PER_VALUE-1:0] tmp;
        tmp = {{VALUE_W{1'b0}}, x};
        return tmp[VALUE_W-1:0];
    endfunction

endpackage

>>> rtl/core/pwpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pwpd_cfg_regs
// Configuration register file with write-only access and reset defaults.
// ----------------------------------------------------------------------------
module pwpd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pwpd_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [pwpd_pkg::TICK_W-1:0]     cfg_wr_data,
    output pwpd_pkg::cfg_t                  cfg
);

    pwpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_pulse   <= pwpd_pkg::ONE_PULSE_RESET;
            cfg_reg.zero_pulse  <= pwpd_pkg::ZERO_PULSE_RESET;
            cfg_reg.bit_gap     <= pwpd_pkg::BIT_GAP_RESET;
            cfg_reg.frame_gap   <= pwpd_pkg::FRAME_GAP_RESET;
            cfg_reg.tolerance   <= pwpd_pkg::TOLERANCE_RESET;
        end else if (cfg_wr_en) begin
            unique case (pwpd_pkg::cfg_index_t'(cfg_wr_index))
                pwpd_pkg::REG_ONE_PULSE:   cfg_reg.one_pulse   <= cfg_wr_data;
                pwpd_pkg::REG_ZERO_PULSE:  cfg_reg.zero_pulse  <= cfg_wr_data;
                pwpd_pkg::REG_BIT_GAP:     cfg_reg.bit_gap     <= cfg_wr_data;
                pwpd_pkg::REG_FRAME_GAP:   cfg_reg.frame_gap   <= cfg_wr_data;
                pwpd_pkg::REG_TOLERANCE:   cfg_reg.tolerance   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/pwpd_store.sv
// ----------------------------------------------------------------------------
// pwpd_store
// Package store: one synchronous memory word per value, registered read
// data, with per-entry valid flags so a clear takes effect at once.
// ----------------------------------------------------------------------------
module pwpd_store (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 clear,
    input  logic                                 wr_en,
    input  logic [pwpd_pkg::ADDR_W-1:0]          wr_addr,
    input  logic [pwpd_pkg::BITS_PER_VALUE-1:0]  wr_data,
    input  logic                                 rd_en,
    input  logic [pwpd_pkg::ADDR_W-1:0]          rd_addr,
    output logic [pwpd_pkg::BITS_PER_VALUE-1:0]  rd_data
);

    logic [pwpd_pkg::BITS_PER_VALUE-1:0]     mem [pwpd_pkg::VALUES_PER_PACKAGE];
    logic [pwpd_pkg::VALUES_PER_PACKAGE-1:0] valid_reg;
    logic [pwpd_pkg::BITS_PER_VALUE-1:0]     rd_data_reg;
    logic                                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written since the last clear reads as zero.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/pwpd_classifier.sv
// ----------------------------------------------------------------------------
// pwpd_classifier
// Window checks of one interval against the configured nominal lengths.
// ----------------------------------------------------------------------------
module pwpd_classifier (
    input  pwpd_pkg::cfg_t                   cfg,
    input  logic [pwpd_pkg::TICK_W-1:0]      interval_ticks,
    output pwpd_pkg::class_t                 cls
);

    localparam int W = pwpd_pkg::TICK_W + 1;

    logic [W-1:0] t_ext;
    logic [W-1:0] t_plus_tol;
    logic         one_win;
    logic         zero_win;

    // Both sides are moved by the tolerance so the compares stay unsigned
    // and never wrap: t > n - tol is t + tol > n.
    function automatic logic in_window(input logic [W-1:0] t,
                                       input logic [W-1:0] t_tol,
                                       input logic [pwpd_pkg::TICK_W-1:0] nominal,
                                       input logic [pwpd_pkg::TICK_W-1:0] tol);
        logic [W-1:0] n_ext;
        logic [W-1:0] n_plus_tol;
        n_ext      = {1'b0, nominal};
        n_plus_tol = n_ext + {1'b0, tol};
        return (t_tol > n_ext) && (t < n_plus_tol);
    endfunction

    always_comb begin
        t_ext       = {1'b0, interval_ticks};
        t_plus_tol  = t_ext + {1'b0, cfg.tolerance};
        one_win     = in_window(t_ext, t_plus_tol, cfg.one_pulse, cfg.tolerance);
        zero_win    = in_window(t_ext, t_plus_tol, cfg.zero_pulse, cfg.tolerance);
        cls.pkg_gap = t_plus_tol > {1'b0, cfg.frame_gap};
        cls.gap_ok  = in_window(t_ext, t_plus_tol, cfg.bit_gap, cfg.tolerance);
        cls.one     = one_win;
        // The one-bit window wins where both windows overlap.
        cls.zero    = !one_win && zero_win;
    end

endmodule

>>> rtl/core/pulse_width_packet_decoder.sv
// ----------------------------------------------------------------------------
// pulse_width_packet_decoder
// Decodes line-edge words into bit results, gap checks and package values.
// ----------------------------------------------------------------------------
// Timing: a word is taken in S_IDLE while the package store is read; its
// result is registered in S_EVAL once the output is free, and no new word
// is taken before that. A package gap that commits emits one value per cycle
// from the store's single read port while the output does not stall.
// Reset: synchronous; configuration returns to defaults, the counter, error
// level and store valid flags clear at once, with no clearing pass.
module pulse_width_packet_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input words.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // interval_ticks[15:0]
    input  logic [0:0]                          s_tuser,   // rising_edge[0]
    // Result words.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // value[7:0], value_index[13:8],
                                                           // error_level[14], zero[15]
    output logic [2:0]                          m_tuser,   // status[2:0]
    output logic                                m_tlast,
    // Configuration writes.
    input  logic                                cfg_wr_en,
    input  logic [pwpd_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [pwpd_pkg::TICK_W-1:0]         cfg_wr_data
);

    localparam int CNT_W  = pwpd_pkg::CNT_W;
    localparam int WORD_W = pwpd_pkg::WORD_W;
    localparam int ADDR_W = pwpd_pkg::ADDR_W;
    localparam int BIT_W  = pwpd_pkg::BIT_W;
    localparam int BITS   = pwpd_pkg::BITS_PER_VALUE;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t                             state_reg;
    logic [CNT_W-1:0]                   bit_count_reg;
    logic [WORD_W-1:0]                  word_idx_reg;
    logic [BIT_W-1:0]                   bit_idx_reg;
    logic [ADDR_W-1:0]                  dump_idx_reg;
    logic                               error_reg;
    logic                               error_next;

    logic                               rising_reg;
    logic [pwpd_pkg::TICK_W-1:0]        ticks_reg;

    logic                               m_tvalid_reg;
    pwpd_pkg::status_t                  m_status_reg;
    logic [pwpd_pkg::VALUE_W-1:0]       m_value_reg;
    logic [pwpd_pkg::INDEX_W-1:0]       m_index_reg;
    logic                               m_last_reg;
    logic                               m_error_reg;

    pwpd_pkg::cfg_t                     cfg;
    pwpd_pkg::class_t                   cls;

    logic                               s_accept;
    logic                               out_free;
    logic                               eval_go;
    logic                               dump_go;
    logic                               dump_last;
    logic                               is_error;
    logic                               is_commit;
    logic                               is_bit;
    logic                               count_full;

    logic                               st_clear;
    logic                               st_wr_en;
    logic [BITS-1:0]                    st_wr_data;
    logic                               st_rd_en;
    logic [ADDR_W-1:0]                  st_rd_addr;
    logic [BITS-1:0]                    st_rd_data;
    logic [BITS-1:0]                    bit_mask;

    logic                               out_load;
    pwpd_pkg::status_t                  out_status;
    logic [pwpd_pkg::VALUE_W-1:0]       out_value;
    logic [pwpd_pkg::INDEX_W-1:0]       out_index;
    logic                               out_last;

    pwpd_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    pwpd_classifier u_cls (
        .cfg            (cfg),
        .interval_ticks (ticks_reg),
        .cls            (cls)
    );

    pwpd_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (st_clear),
        .wr_en   (st_wr_en),
        .wr_addr (word_idx_reg[ADDR_W-1:0]),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign eval_go  = (state_reg == S_EVAL) && out_free;
    assign dump_go  = (state_reg == S_DUMP) && out_free;
    assign dump_last = (dump_idx_reg == ADDR_W'(pwpd_pkg::VALUES_PER_PACKAGE - 1));
    assign count_full = (bit_count_reg == CNT_W'(pwpd_pkg::TOTAL_BITS));

    always_comb begin
        is_error  = 1'b0;
        is_commit = 1'b0;
        is_bit    = 1'b0;
        if (rising_reg) begin
            if (cls.pkg_gap) begin
                is_commit = count_full;
                is_error  = !count_full;
            end else begin
                is_error = !cls.gap_ok;
            end
        end else begin
            is_error = !cls.one && !cls.zero;
            is_bit   = cls.one || cls.zero;
        end
    end

    assign error_next = error_reg ^ (eval_go && is_error);

    // Read-modify-write of the word that holds the current bit. Only one word
    // is in flight at a time, so the write always lands before the next read.
    always_comb begin
        bit_mask   = BITS'(1) << bit_idx_reg;
        st_wr_data = cls.one ? (st_rd_data | bit_mask) : (st_rd_data & ~bit_mask);
        st_wr_en   = eval_go && is_bit && (bit_count_reg < CNT_W'(pwpd_pkg::TOTAL_BITS));
        st_clear   = (eval_go && is_error) || (dump_go && dump_last);
        st_rd_en   = s_accept || (eval_go && is_commit) || (dump_go && !dump_last);
        if (s_accept) begin
            st_rd_addr = word_idx_reg[ADDR_W-1:0];
        end else if (state_reg == S_EVAL) begin
            st_rd_addr = '0;
        end else begin
            st_rd_addr = dump_idx_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        out_load = (eval_go && !is_commit) || dump_go;
        if (state_reg == S_DUMP) begin
            out_status = pwpd_pkg::ST_VALUE;
            out_value  = pwpd_pkg::to_value(st_rd_data);
            out_index  = pwpd_pkg::INDEX_W'(dump_idx_reg);
            out_last   = dump_last;
        end else begin
            if (is_error) begin
                out_status = pwpd_pkg::ST_ERROR;
            end else if (rising_reg) begin
                out_status = pwpd_pkg::ST_GAP_OK;
            end else if (cls.one) begin
                out_status = pwpd_pkg::ST_ONE;
            end else begin
                out_status = pwpd_pkg::ST_ZERO;
            end
            out_value = '0;
            out_index = '0;
            out_last  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bit_count_reg <= '0;
            word_idx_reg  <= '0;
            bit_idx_reg   <= '0;
            dump_idx_reg  <= '0;
            error_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            error_reg <= error_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        if (is_commit) begin
                            dump_idx_reg <= '0;
                            state_reg    <= S_DUMP;
                        end else begin
                            state_reg <= S_IDLE;
                            if (is_error) begin
                                bit_count_reg <= '0;
                                word_idx_reg  <= '0;
                                bit_idx_reg   <= '0;
                            end else if (is_bit) begin
                                if (bit_count_reg < CNT_W'(pwpd_pkg::TOTAL_BITS)) begin
                                    if (bit_idx_reg == BIT_W'(BITS - 1)) begin
                                        bit_idx_reg  <= '0;
                                        word_idx_reg <= word_idx_reg + WORD_W'(1);
                                    end else begin
                                        bit_idx_reg <= bit_idx_reg + BIT_W'(1);
                                    end
                                end
                                if (bit_count_reg <= CNT_W'(pwpd_pkg::TOTAL_BITS)) begin
                                    bit_count_reg <= bit_count_reg + CNT_W'(1);
                                end
                            end
                        end
                    end
                end
                S_DUMP: begin
                    if (out_free) begin
                        if (dump_last) begin
                            bit_count_reg <= '0;
                            word_idx_reg  <= '0;
                            bit_idx_reg   <= '0;
                            state_reg     <= S_IDLE;
                        end else begin
                            dump_idx_reg <= dump_idx_reg + ADDR_W'(1);
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rising_reg <= s_tuser[0];
            ticks_reg  <= s_tdata;
        end
        if (out_load) begin
            m_status_reg <= out_status;
            m_value_reg  <= out_value;
            m_index_reg  <= out_index;
            m_last_reg   <= out_last;
            m_error_reg  <= error_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_error_reg, m_index_reg, m_value_reg};

    // An error result always leaves an empty package behind it.
    a_error_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_status == pwpd_pkg::ST_ERROR) |=> (bit_count_reg == '0))
        else $error("bit counter not cleared after an error");

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= CNT_W'(pwpd_pkg::TOTAL_BITS + 1))
        else $error("bit counter beyond saturation");

    // Only the package values of a commit can be a non-final result.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg != pwpd_pkg::ST_VALUE) |-> m_last_reg)
        else $error("single result without last");

    a_dump_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        dump_go |=> (m_tvalid_reg && m_status_reg == pwpd_pkg::ST_VALUE))
        else $error("commit step did not present a value");

endmodule
